>>> rtl/dtq_pkg.sv
// Shared types and codes for the deadline timer queue.
package dtq_pkg;

	// Request modes
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_FIRED  = 2'd0;
	localparam logic [1:0] KIND_ADDED  = 2'd1;
	localparam logic [1:0] KIND_FULL   = 2'd2;
	localparam logic [1:0] KIND_CANCEL = 2'd3;

	// Most timers that one tick may fire
	localparam int MAX_FIRE = 16;

	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] delay_ms;
		logic [7:0]  owner_id;
		logic [15:0] message_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  fired_owner;
		logic [15:0] fired_message;
		logic        deliver_to_owner;
		logic [4:0]  removed_count;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] deadline;
		logic [7:0]  owner;
		logic [15:0] message;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/dtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/deadline_timer_queue_top.sv
// Deadline timer queue: up to QUEUE_DEPTH timers sorted by deadline, held in one entry RAM.
// A sequencer walks the RAM one entry at a time, read then check/write, through one
// shared 32-bit add/subtract unit that forms deadlines, advances the time and compares them by signed difference.
// An add walks from the tail, moving each later entry up until a compare stops the walk
// or every entry has moved, then writes the new one; a full-queue add answers without a
// walk. A cancel walks every entry and compacts the rest. A tick fires expired timers from
// the head until an unexpired one, the firing cap or the end of the queue stops it, then
// compacts the rest; it gives no result when nothing expires or the queue is empty.
// Each result leaves through a one-deep output register; the sequencer waits on it only when
// a second result is ready before the first one is taken. No request is taken while a
// previous one is in progress. The queue is empty after reset; no clearing pass is needed.
module deadline_timer_queue_top
	import dtq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int FIRE_CAP = (QUEUE_DEPTH < MAX_FIRE) ? QUEUE_DEPTH : MAX_FIRE;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_WRNEW = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0]    state_q;
	logic [1:0]    op_q;
	logic          cmp_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] dst_q;
	logic [CW-1:0] n_q;
	logic [31:0]   now_q;
	logic [31:0]   dl_q;
	logic [7:0]    own_q;
	logic [15:0]   msg_q;
	rsp_t          pend_q;
	logic          pend_v_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;
	logic [CW-1:0]      rd_ptr;

	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic        alu_sub;
	logic [31:0] alu_y;
	logic        later;

	logic          req_fire;
	logic          push_ok;
	logic          fire_hit;
	logic          push;
	logic          keep;
	logic [CW-1:0] diff;
	logic [4:0]    removed_sat;
	rsp_t          fired_rsp;
	rsp_t          full_rsp;
	rsp_t          added_rsp;
	rsp_t          cancel_rsp;
	rsp_t          out_rsp;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rd_entry  = entry_t'(ram_rdata);

	// Shared add/subtract unit: deadline and time updates in idle, compares elsewhere
	always_comb begin
		if (state_q == S_IDLE) begin
			alu_a   = now_q;
			alu_b   = (req.mode == MODE_ADD) ? {8'd0, req.delay_ms} : 32'd1;
			alu_sub = 1'b0;
		end else begin
			alu_a   = rd_entry.deadline;
			alu_b   = (op_q == MODE_ADD) ? dl_q : now_q;
			alu_sub = 1'b1;
		end
		alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	end

	// Entry deadline lies strictly after the reference time
	assign later = (alu_y != 32'd0) && !alu_y[31];

	// Output slot handling
	assign push_ok  = !rsp_valid_q;
	assign fire_hit = (state_q == S_CHK) && (op_q == MODE_TICK) && !cmp_q && !later;
	assign push     = (fire_hit && pend_v_q && push_ok) || ((state_q == S_FLUSH) && push_ok);
	assign keep     = !((op_q == MODE_CANCEL) && (rd_entry.owner == own_q));

	// Saturated count of entries dropped by a cancel
	always_comb begin
		diff = n_q - dst_q;
		if (int'(diff) > 31) begin
			removed_sat = 5'd31;
		end else begin
			removed_sat = 5'(diff);
		end
	end

	always_comb begin
		fired_rsp                  = '0;
		fired_rsp.kind             = KIND_FIRED;
		fired_rsp.fired_owner      = rd_entry.owner;
		fired_rsp.fired_message    = rd_entry.message;
		fired_rsp.deliver_to_owner = (rd_entry.owner != 8'd0);
	end

	// Build the other result words and the outgoing word with its last flag
	always_comb begin
		full_rsp                 = '0;
		full_rsp.kind            = KIND_FULL;
		added_rsp                = '0;
		added_rsp.kind           = KIND_ADDED;
		cancel_rsp               = '0;
		cancel_rsp.kind          = KIND_CANCEL;
		cancel_rsp.removed_count = removed_sat;
		out_rsp                  = pend_q;
		out_rsp.last             = (state_q == S_FLUSH);
	end

	// RAM read: an add walks downward from the tail, all else walks upward
	assign rd_ptr    = (op_q == MODE_ADD) ? (idx_q - 1'b1) : idx_q;
	assign ram_raddr = rd_ptr[AW-1:0];
	assign ram_re    = (state_q == S_RD) && !(cmp_q && (idx_q == n_q));

	// RAM write: shift for insert, compaction, or the new entry
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		if (state_q == S_CHK && cmp_q && keep) begin
			ram_we    = 1'b1;
			ram_waddr = dst_q[AW-1:0];
		end else if (state_q == S_CHK && op_q == MODE_ADD && !cmp_q && later) begin
			ram_we = 1'b1;
		end else if (state_q == S_WRNEW) begin
			ram_we    = 1'b1;
			ram_wdata = {dl_q, own_q, msg_q};
		end
	end

	dtq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= MODE_TICK;
			cmp_q    <= 1'b0;
			idx_q    <= '0;
			dst_q    <= '0;
			n_q      <= '0;
			now_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q     <= req.mode;
						pend_v_q <= 1'b0;
						dst_q    <= '0;
						idx_q    <= '0;
						unique case (req.mode)
							MODE_TICK: begin
								now_q   <= alu_y;
								cmp_q   <= 1'b0;
								state_q <= (n_q == '0) ? S_IDLE : S_RD;
							end
							MODE_ADD: begin
								cmp_q <= 1'b0;
								idx_q <= n_q;
								if (n_q == CW'(QUEUE_DEPTH)) begin
									state_q <= S_FLUSH;
								end else begin
									state_q <= (n_q == '0) ? S_WRNEW : S_RD;
								end
							end
							MODE_CANCEL: begin
								cmp_q   <= 1'b1;
								state_q <= S_RD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RD: begin
					if (cmp_q && idx_q == n_q) begin
						n_q     <= dst_q;
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (cmp_q) begin
						if (keep) begin
							dst_q <= dst_q + 1'b1;
						end
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end else if (op_q == MODE_ADD) begin
						if (later) begin
							idx_q   <= idx_q - 1'b1;
							state_q <= (idx_q == CW'(1)) ? S_WRNEW : S_RD;
						end else begin
							state_q <= S_WRNEW;
						end
					end else if (!later) begin
						if (!pend_v_q || push_ok) begin
							pend_v_q <= 1'b1;
							idx_q    <= idx_q + 1'b1;
							if ((idx_q + 1'b1) == n_q || (idx_q + 1'b1) == CW'(FIRE_CAP)) begin
								cmp_q <= 1'b1;
							end
							state_q <= S_RD;
						end
					end else if (pend_v_q) begin
						cmp_q   <= 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WRNEW: begin
					n_q     <= n_q + 1'b1;
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (push_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold request fields and the pending result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			own_q <= req.owner_id;
			msg_q <= req.message_handle;
			dl_q  <= alu_y;
			if (req.mode == MODE_ADD) begin
				pend_q <= full_rsp;
			end
		end
		if (fire_hit && (!pend_v_q || push_ok)) begin
			pend_q <= fired_rsp;
		end
		if (state_q == S_WRNEW) begin
			pend_q <= added_rsp;
		end
		if (state_q == S_RD && cmp_q && idx_q == n_q && op_q == MODE_CANCEL) begin
			pend_q <= cancel_rsp;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsp_q <= out_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(QUEUE_DEPTH))
		else $error("queue fill exceeds depth");

	a_write_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) <= n_q))
		else $error("entry write beyond queue fill");

	a_time_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_fire && req.mode == MODE_TICK) |=> $stable(now_q))
		else $error("time advanced without a tick");

	a_fire_pending_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && op_q == MODE_TICK && pend_v_q) |-> (pend_q.kind == KIND_FIRED))
		else $error("pending result during firing is not a fired timer");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the deadline timer queue: directed and random requests.
module tb;
	import dtq_pkg::*;

	localparam int DEPTH           = 16;
	localparam int RANDOM_REQUESTS = 200;
	localparam int CALM_TAIL       = 30;
	localparam int DRAIN_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT  = 2000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Requests still to send, timers the block should hold, results still owed
	req_t        request_q[$];
	entry_t      timer_list[$];
	logic [31:0] now_count;
	rsp_t        timer_results_q[$];

	bit calm = 1'b0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int n_adds = 0, n_full = 0, n_ticks = 0, n_cancels = 0, n_fired = 0, n_removed = 0;

	deadline_timer_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// Deadline a lies after b when a - b is positive as a signed 32-bit value
	function automatic bit lies_after(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d != 32'd0) && !d[31];
	endfunction

	// Apply one request to the timer list and queue the results it causes
	task automatic run_timer_request(input req_t r);
		rsp_t        res;
		entry_t      e;
		entry_t      rebuilt[$];
		logic [31:0] deadline;
		int          fired;
		int          pos;
		int          removed;
		res = '0;
		case (r.mode)
			MODE_TICK: begin
				n_ticks++;
				now_count = now_count + 32'd1;
				fired = 0;
				while (fired < MAX_FIRE && timer_list.size() > 0
						&& !lies_after(timer_list[0].deadline, now_count)) begin
					e = timer_list.pop_front();
					res = '0;
					res.kind = KIND_FIRED;
					res.fired_owner = e.owner;
					res.fired_message = e.message;
					res.deliver_to_owner = (e.owner != 8'd0);
					timer_results_q.push_back(res);
					fired++;
				end
				// mark the final firing of this tick
				if (fired > 0) begin
					res = timer_results_q.pop_back();
					res.last = 1'b1;
					timer_results_q.push_back(res);
				end
				n_fired += fired;
			end
			MODE_ADD: begin
				n_adds++;
				res.last = 1'b1;
				if (timer_list.size() >= DEPTH) begin
					res.kind = KIND_FULL;
					n_full++;
				end else begin
					deadline = now_count + {8'd0, r.delay_ms};
					pos = 0;
					while (pos < timer_list.size() && !lies_after(timer_list[pos].deadline, deadline))
						pos++;
					e.deadline = deadline;
					e.owner = r.owner_id;
					e.message = r.message_handle;
					// insert after every timer not later than the new one
					for (int i = 0; i < pos; i++)
						rebuilt.push_back(timer_list[i]);
					rebuilt.push_back(e);
					for (int i = pos; i < timer_list.size(); i++)
						rebuilt.push_back(timer_list[i]);
					timer_list = rebuilt;
					res.kind = KIND_ADDED;
				end
				timer_results_q.push_back(res);
			end
			MODE_CANCEL: begin
				n_cancels++;
				removed = 0;
				foreach (timer_list[i]) begin
					if (timer_list[i].owner == r.owner_id)
						removed++;
					else
						rebuilt.push_back(timer_list[i]);
				end
				timer_list = rebuilt;
				n_removed += removed;
				if (removed > 31)
					removed = 31;
				res.kind = KIND_CANCEL;
				res.removed_count = removed[4:0];
				res.last = 1'b1;
				timer_results_q.push_back(res);
			end
			default: ;
		endcase
	endtask

	function automatic req_t make_request(input logic [1:0] mode, input logic [23:0] delay,
			input logic [7:0] owner, input logic [15:0] message);
		req_t r;
		r.mode = mode;
		r.delay_ms = delay;
		r.owner_id = owner;
		r.message_handle = message;
		return r;
	endfunction

	// Draw a random request; the phase shifts the mix toward adds or ticks
	function automatic req_t random_request(input int phase);
		req_t r;
		int   pick;
		int   tick_w;
		int   add_w;
		tick_w = (phase == 0) ? 50 : (phase == 1) ? 20 : 70;
		add_w  = (phase == 0) ? 35 : (phase == 1) ? 70 : 20;
		pick = $urandom_range(0, 99);
		r.message_handle = 16'($urandom_range(0, 16'hFFFF));
		r.owner_id = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
			: 8'($urandom_range(0, 255));
		case ($urandom_range(0, 19))
			0, 1:          r.delay_ms = 24'($urandom_range(0, 24'hFFFFFF));
			2, 3, 4, 5, 6: r.delay_ms = 24'($urandom_range(0, 40));
			default:       r.delay_ms = 24'($urandom_range(0, 6));
		endcase
		if (pick < tick_w)
			r.mode = MODE_TICK;
		else if (pick < tick_w + add_w)
			r.mode = MODE_ADD;
		else
			r.mode = MODE_CANCEL;
		return r;
	endfunction

	// Request driver: send queued requests with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		int idle_left;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			idle_left = 0;
		end else begin
			if (req_valid && req_ready)
				run_timer_request(req);
			calm <= (request_q.size() <= CALM_TAIL);
			if (!req_valid || req_ready) begin
				if (idle_left > 0) begin
					idle_left--;
					req_valid <= 1'b0;
				end else if (request_q.size() == 0) begin
					req_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					idle_left = $urandom_range(0, 6);
					req_valid <= 1'b0;
				end else begin
					req <= request_q.pop_front();
					req_valid <= 1'b1;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Result monitor: compare each result with the oldest owed one, stall at random
	always @(posedge clk or negedge arst_n) begin
		int   stall_left;
		rsp_t owed;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (timer_results_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %p", $time, rsp);
					mismatches++;
				end else begin
					owed = timer_results_q.pop_front();
					check_field("kind", 32'(owed.kind), 32'(rsp.kind));
					check_field("fired_owner", 32'(owed.fired_owner), 32'(rsp.fired_owner));
					check_field("fired_message", 32'(owed.fired_message),
						32'(rsp.fired_message));
					check_field("deliver_to_owner", 32'(owed.deliver_to_owner),
						32'(rsp.deliver_to_owner));
					check_field("removed_count", 32'(owed.removed_count),
						32'(rsp.removed_count));
					check_field("last", 32'(owed.last), 32'(rsp.last));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 6);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int sent;
		req_t r;
		now_count = 32'd0;

		// Directed: empty tick, ignored mode, field extremes, zero delay, idle tick, two cancels
		request_q.push_back(make_request(MODE_TICK, 24'd0, 8'd0, 16'd0));
		request_q.push_back(make_request(2'd3, 24'hFFFFFF, 8'hFF, 16'hFFFF));
		request_q.push_back(make_request(MODE_ADD, 24'd0, 8'd0, 16'd0));
		request_q.push_back(make_request(MODE_ADD, 24'hFFFFFF, 8'hFF, 16'hFFFF));
		request_q.push_back(make_request(MODE_TICK, 24'd0, 8'd0, 16'd0));
		request_q.push_back(make_request(MODE_TICK, 24'd0, 8'd0, 16'd0));
		request_q.push_back(make_request(MODE_CANCEL, 24'd0, 8'hFF, 16'd0));
		request_q.push_back(make_request(MODE_CANCEL, 24'd0, 8'd0, 16'd0));
		// Fill the queue with mixed and equal deadlines, overflow it, then fire all at once
		for (int i = 0; i <= DEPTH; i++)
			request_q.push_back(make_request(MODE_ADD, (i % 3 == 0) ? 24'd0 : 24'd1,
				8'((i * 37) & 8'hFF), 16'(16'h1000 + i)));
		request_q.push_back(make_request(MODE_TICK, 24'd0, 8'd0, 16'd0));

		// Random part in phases; ignored mode-3 requests do not count
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			if ($urandom_range(0, 24) == 0) begin
				r = random_request(0);
				r.mode = 2'd3;
			end else begin
				r = random_request((sent / 40) % 3);
				sent++;
			end
			request_q.push_back(r);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || req_valid)
			@(posedge clk);
		while (timer_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d adds (%0d refused as full), %0d ticks and %0d cancels",
			n_adds, n_full, n_ticks, n_cancels);
		$display("%0d timers fired, %0d removed by cancel, %0d mismatches",
			n_fired, n_removed, mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/dtq_pkg.sv
rtl/dtq_ram.sv
rtl/deadline_timer_queue_top.sv
tb/tb.sv
